[design/sxg_pkg.sv]
// sxg_pkg: shared types and constants for the horizontal gradient stream.
// Holds item and result structs, register codes, reset values and queue depths.
// No dependencies.
package sxg_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int PIX_W = 8;
	localparam int COEF_W = 8;
	localparam int DIM_W = 11;
	localparam int GRAD_W = 19;
	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int NUM_TAPS = 6;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int SETTLE_CYCLES = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_UP_LEFT,
		REG_COEF_UP_RIGHT,
		REG_COEF_LEFT,
		REG_COEF_RIGHT,
		REG_COEF_DOWN_LEFT,
		REG_COEF_DOWN_RIGHT,
		REG_LINE_WIDTH,
		REG_LINE_COUNT
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t up_left;
		coef_t up_right;
		coef_t left;
		coef_t right;
		coef_t down_left;
		coef_t down_right;
	} coefs_t;

	typedef struct packed {
		coefs_t           coef;
		logic [DIM_W-1:0] line_width;
		logic [DIM_W-1:0] line_count;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             is_pad;
		logic             frame_start;
	} pix_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gradient;
		logic                     frame_end;
	} res_t;

	// neighbor values of one output pixel, already zeroed outside the image
	typedef struct packed {
		logic [PIX_W-1:0] up_left;
		logic [PIX_W-1:0] up_right;
		logic [PIX_W-1:0] left;
		logic [PIX_W-1:0] right;
		logic [PIX_W-1:0] down_left;
		logic [PIX_W-1:0] down_right;
		logic             frame_end;
	} taps_t;

	localparam coef_t COEF_UP_LEFT_RST = -8'sd16;
	localparam coef_t COEF_UP_RIGHT_RST = 8'sd16;
	localparam coef_t COEF_LEFT_RST = -8'sd32;
	localparam coef_t COEF_RIGHT_RST = 8'sd32;
	localparam coef_t COEF_DOWN_LEFT_RST = -8'sd16;
	localparam coef_t COEF_DOWN_RIGHT_RST = 8'sd16;
	localparam logic [DIM_W-1:0] LINE_WIDTH_RST = 11'd640;
	localparam logic [DIM_W-1:0] LINE_COUNT_RST = 11'd480;

endpackage

[design/sxg_fifo.sv]
// sxg_fifo: small synchronous queue with registered storage.
// Used between front and back and on the result side. Depends on nothing.
module sxg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             wr_en;
	logic             rd_en;

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_en = wr && !full;
	assign rd_en = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[design/sxg_regs.sv]
// sxg_regs: configuration register file (coefficients and image size).
// Depends on sxg_pkg.
module sxg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sxg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sxg_pkg::CFG_DATA_W-1:0]     cfg_data,
	output sxg_pkg::cfg_t                      cfg,
	output logic                               cfg_wr
);

	sxg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef.up_left <= sxg_pkg::COEF_UP_LEFT_RST;
			cfg_q.coef.up_right <= sxg_pkg::COEF_UP_RIGHT_RST;
			cfg_q.coef.left <= sxg_pkg::COEF_LEFT_RST;
			cfg_q.coef.right <= sxg_pkg::COEF_RIGHT_RST;
			cfg_q.coef.down_left <= sxg_pkg::COEF_DOWN_LEFT_RST;
			cfg_q.coef.down_right <= sxg_pkg::COEF_DOWN_RIGHT_RST;
			cfg_q.line_width <= sxg_pkg::LINE_WIDTH_RST;
			cfg_q.line_count <= sxg_pkg::LINE_COUNT_RST;
		end else if (cfg_wr) begin
			case (sxg_pkg::reg_idx_t'(cfg_index))
				sxg_pkg::REG_COEF_UP_LEFT: begin
					cfg_q.coef.up_left <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_COEF_UP_RIGHT: begin
					cfg_q.coef.up_right <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_COEF_LEFT: begin
					cfg_q.coef.left <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_COEF_RIGHT: begin
					cfg_q.coef.right <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_COEF_DOWN_LEFT: begin
					cfg_q.coef.down_left <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_COEF_DOWN_RIGHT: begin
					cfg_q.coef.down_right <= cfg_data[sxg_pkg::COEF_W-1:0];
				end
				sxg_pkg::REG_LINE_WIDTH: begin
					cfg_q.line_width <= cfg_data[sxg_pkg::DIM_W-1:0];
				end
				sxg_pkg::REG_LINE_COUNT: begin
					cfg_q.line_count <= cfg_data[sxg_pkg::DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/sxg_front.sv]
// sxg_front: accepts pixels, tracks position in the image, keeps the two-line
// history in ring memories and gathers the six neighbors of each output pixel.
// Depends on sxg_pkg.
module sxg_front #(
	parameter int MAX_WIDTH = sxg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sxg_pkg::MAX_HEIGHT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sxg_pkg::cfg_t  cfg,
	input  logic           cfg_wr,
	input  logic           push,
	input  sxg_pkg::pix_t  item,
	output logic           full,
	input  logic           mid_full,
	output logic           mid_push,
	output sxg_pkg::taps_t mid_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int COUNT_LIMIT = MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2;
	localparam int CW = $clog2(COUNT_LIMIT + 1);
	localparam int LINE_DEPTH = 2 * MAX_WIDTH + 3;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int RING = 1 << AW;
	localparam int SW = $clog2(sxg_pkg::SETTLE_CYCLES + 1);
	localparam int PW = sxg_pkg::PIX_W;

	// clamped geometry, recomputed every cycle
	logic [WW-1:0] wc_c;
	logic [HW-1:0] hc_c;
	logic [WW-1:0] wc_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] last_q;
	logic [CW-1:0] thr_w2_q;
	logic [CW-1:0] thr_2w_q;
	logic [CW-1:0] thr_2w2_q;
	logic [AW-1:0] off_w_q;
	logic [AW-1:0] off_w2_q;
	logic [AW-1:0] off_2w_q;
	logic [AW-1:0] off_2w2_q;
	logic [SW-1:0] settle_q;

	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] p_c;
	logic [PW-1:0] pix_c;
	logic          has_res_c;
	logic          accept;

	logic [PW-1:0] hist1_q;
	logic [PW-1:0] hist2_q;
	logic [PW-1:0] mem_a [RING];
	logic [PW-1:0] mem_b [RING];

	logic          v_s1;
	logic [PW-1:0] cur_s1;
	logic [PW-1:0] dl_s1;
	logic [PW-1:0] rd_w_s1;
	logic [PW-1:0] rd_w2_s1;
	logic [PW-1:0] rd_2w_s1;
	logic [PW-1:0] rd_2w2_s1;
	logic          m_w2_s1;
	logic          m_2w_s1;
	logic          m_2w2_s1;
	logic          end_s1;

	always_comb begin
		if (cfg.line_width == '0) begin
			wc_c = WW'(1);
		end else if (32'(cfg.line_width) > MAX_WIDTH) begin
			wc_c = WW'(MAX_WIDTH);
		end else begin
			wc_c = WW'(cfg.line_width);
		end
		if (cfg.line_count == '0) begin
			hc_c = HW'(1);
		end else if (32'(cfg.line_count) > MAX_HEIGHT) begin
			hc_c = HW'(MAX_HEIGHT);
		end else begin
			hc_c = HW'(cfg.line_count);
		end
	end

	always_ff @(posedge clk) begin
		wc_q <= wc_c;
		total_q <= CW'(wc_c) * CW'(hc_c);
		thr_w2_q <= CW'(wc_c) + CW'(2);
		thr_2w_q <= CW'(wc_c) << 1;
		thr_2w2_q <= (CW'(wc_c) << 1) + CW'(2);
		off_w_q <= AW'(wc_c);
		off_w2_q <= AW'(wc_c) + AW'(2);
		off_2w_q <= AW'(wc_c) << 1;
		off_2w2_q <= (AW'(wc_c) << 1) + AW'(2);
		last_q <= total_q + CW'(wc_q);
	end

	assign p_c = item.frame_start ? '0 : cnt_q;
	assign pix_c = (item.is_pad || (p_c >= total_q)) ? '0 : item.pixel;
	assign has_res_c = (p_c > CW'(wc_q)) && (p_c <= last_q);

	assign full = (settle_q != '0) || (v_s1 && mid_full);
	assign accept = push && !full;
	assign mid_push = v_s1 && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SW'(sxg_pkg::SETTLE_CYCLES);
			cnt_q <= '0;
			wptr_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (cfg_wr) begin
				settle_q <= SW'(sxg_pkg::SETTLE_CYCLES);
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (accept) begin
				cnt_q <= (p_c < CW'(COUNT_LIMIT)) ? p_c + 1'b1 : p_c;
				wptr_q <= wptr_q + 1'b1;
				v_s1 <= has_res_c;
			end else if (mid_push) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hist1_q <= pix_c;
			hist2_q <= hist1_q;
			cur_s1 <= pix_c;
			dl_s1 <= hist2_q;
			end_s1 <= (p_c == last_q);
			m_w2_s1 <= (p_c >= thr_w2_q);
			m_2w_s1 <= (p_c >= thr_2w_q);
			m_2w2_s1 <= (p_c >= thr_2w2_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_a[wptr_q] <= pix_c;
			rd_w_s1 <= mem_a[wptr_q - off_w_q];
			rd_w2_s1 <= mem_a[wptr_q - off_w2_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_b[wptr_q] <= pix_c;
			rd_2w_s1 <= mem_b[wptr_q - off_2w_q];
			rd_2w2_s1 <= mem_b[wptr_q - off_2w2_q];
		end
	end

	always_comb begin
		mid_data.up_left = m_2w2_s1 ? rd_2w2_s1 : '0;
		mid_data.up_right = m_2w_s1 ? rd_2w_s1 : '0;
		mid_data.left = m_w2_s1 ? rd_w2_s1 : '0;
		mid_data.right = rd_w_s1;
		mid_data.down_left = dl_s1;
		mid_data.down_right = cur_s1;
		mid_data.frame_end = end_s1;
	end

endmodule

[design/sxg_back.sv]
// sxg_back: multiply-accumulate pipeline, six products then one sum.
// Issues work only when the result queue has a free slot. Depends on sxg_pkg.
module sxg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sxg_pkg::coefs_t coef,
	input  logic           mid_empty,
	input  sxg_pkg::taps_t mid_data,
	output logic           mid_pop,
	output logic           res_valid,
	output sxg_pkg::res_t  res,
	input  logic           res_taken
);

	localparam int IW = $clog2(sxg_pkg::OUT_DEPTH + 1);
	localparam int NT = sxg_pkg::NUM_TAPS;

	logic [IW-1:0] inflight_q;

	logic                               v_s2;
	logic                               end_s2;
	logic signed [sxg_pkg::PROD_W-1:0]  prod_s2 [NT];
	logic                               v_s3;
	logic                               end_s3;
	logic signed [sxg_pkg::GRAD_W-1:0]  sum_s3;
	logic signed [sxg_pkg::GRAD_W-1:0]  sum_c;

	function automatic logic signed [sxg_pkg::PROD_W-1:0] mul(
		input sxg_pkg::coef_t c,
		input logic [sxg_pkg::PIX_W-1:0] px
	);
		mul = c * $signed({1'b0, px});
	endfunction

	assign mid_pop = !mid_empty && (inflight_q < IW'(sxg_pkg::OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= mid_pop;
			v_s3 <= v_s2;
			if (mid_pop && !res_taken) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (!mid_pop && res_taken) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2[0] <= mul(coef.up_left, mid_data.up_left);
		prod_s2[1] <= mul(coef.up_right, mid_data.up_right);
		prod_s2[2] <= mul(coef.left, mid_data.left);
		prod_s2[3] <= mul(coef.right, mid_data.right);
		prod_s2[4] <= mul(coef.down_left, mid_data.down_left);
		prod_s2[5] <= mul(coef.down_right, mid_data.down_right);
		end_s2 <= mid_data.frame_end;
		sum_s3 <= sum_c;
		end_s3 <= end_s2;
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NT; k++) begin
			sum_c = sum_c + sxg_pkg::GRAD_W'(prod_s2[k]);
		end
	end

	assign res_valid = v_s3;
	assign res.gradient = sum_s3;
	assign res.frame_end = end_s3;

endmodule

[design/sobel_x_gradient_stream.sv]
// sobel_x_gradient_stream: horizontal 3x3 gradient over a raster pixel stream.
// Top level; uses sxg_pkg, sxg_regs, sxg_front, sxg_fifo and sxg_back.
//
// Input side is a queue write port: item (pixel, is_pad, frame_start) is
// taken on a clock edge with push high and full low. Result side is a queue
// read port: result (gradient, frame_end) is valid while empty is low and is
// removed on an edge with pop high. Registers are written over cfg_valid /
// cfg_ready / cfg_index / cfg_data; cfg_ready is always high.
// The result for pixel q comes out with the item at index q+W+1, so W+1 pad
// items must follow each image. It shows on the result port once that item is
// taken and has passed the line-memory read, the middle queue, the multiply
// and sum stages and the result queue.
// Throughput is one item per clock while full is low, set by the single write
// port of the two line memories (2^ceil(log2(2*MAX_WIDTH+3)) bytes each).
// Reset clears counters and queues and loads the default registers; full
// stays high after reset and after every register write while the image
// geometry is recomputed.
// A stalled receiver fills the 4-entry result queue, then the 4-entry middle
// queue and the read stage, after which full rises; no result is dropped.
module sobel_x_gradient_stream #(
	parameter int MAX_WIDTH = sxg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sxg_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  sxg_pkg::pix_t                  item,
	output logic                           empty,
	input  logic                           pop,
	output sxg_pkg::res_t                  result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sxg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sxg_pkg::CFG_DATA_W-1:0] cfg_data
);

	sxg_pkg::cfg_t  cfg;
	logic           cfg_wr;
	logic           mid_full;
	logic           mid_push;
	sxg_pkg::taps_t mid_wdata;
	logic           mid_empty;
	logic           mid_pop;
	sxg_pkg::taps_t mid_rdata;
	logic           res_valid;
	sxg_pkg::res_t  res;
	logic           res_taken;

	assign res_taken = pop && !empty;

	sxg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.cfg_wr    (cfg_wr)
	);

	sxg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_wr   (cfg_wr),
		.push     (push),
		.item     (item),
		.full     (full),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_data (mid_wdata)
	);

	sxg_fifo #(
		.WIDTH ($bits(sxg_pkg::taps_t)),
		.DEPTH (sxg_pkg::MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.rd     (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	sxg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (cfg.coef),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_taken (res_taken)
	);

	sxg_fifo #(
		.WIDTH ($bits(sxg_pkg::res_t)),
		.DEPTH (sxg_pkg::OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.wdata  (res),
		.full   (),
		.rd     (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

[design/sxg_checker.sv]
// sxg_port_checker: port-level assertions for sobel_x_gradient_stream, with bind.
// Depends on sxg_pkg.
module sxg_port_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          push,
	input logic          full,
	input logic          empty,
	input logic          pop,
	input sxg_pkg::res_t result,
	input logic          cfg_valid,
	input logic          cfg_ready
);

	logic [31:0] outstanding_q;
	logic        in_acc;
	logic        out_acc;

	assign in_acc = push && !full;
	assign out_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_acc && !out_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// geometry recompute blocks input after a register write
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> full ##1 full)
		else $error("input taken too soon after register write");

	// every result needs an earlier pixel
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (outstanding_q != '0))
		else $error("result without a prior pixel");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(result))
		else $error("result changed while waiting");

endmodule

bind sobel_x_gradient_stream sxg_port_checker u_sxg_port_checker (.*);

[tb/sxg_checker.sv]
// sxg_checker: watches the pixel, result and register channels of the
// horizontal gradient stream, predicts every gradient and compares it.
// Depends on sxg_pkg; instantiated next to the block by testbench.
module sxg_checker import sxg_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  pix_t                  item,
	input  logic                  empty,
	input  logic                  pop,
	input  res_t                  result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HIST_DEPTH = 4096;
	localparam int unsigned RX_LIMIT = MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2;

	cfg_t             regs;
	logic [PIX_W-1:0] pix_hist [HIST_DEPTH];
	int unsigned      wr_ptr;
	int unsigned      rx_count;
	res_t             grad_queue [$];

	function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// pixel pos requests back; zero if that lies before the image start
	function automatic int nbr(int unsigned p, int unsigned pos);
		if (pos > p) return 0;
		return int'(pix_hist[(wr_ptr - pos) % HIST_DEPTH]);
	endfunction

	task automatic reset_model();
		regs.coef.up_left = COEF_UP_LEFT_RST;
		regs.coef.up_right = COEF_UP_RIGHT_RST;
		regs.coef.left = COEF_LEFT_RST;
		regs.coef.right = COEF_RIGHT_RST;
		regs.coef.down_left = COEF_DOWN_LEFT_RST;
		regs.coef.down_right = COEF_DOWN_RIGHT_RST;
		regs.line_width = LINE_WIDTH_RST;
		regs.line_count = LINE_COUNT_RST;
		foreach (pix_hist[i]) pix_hist[i] = '0;
		wr_ptr = 0;
		rx_count = 0;
		grad_queue.delete();
		fail_count = 0;
		pending = 0;
		results_checked = 0;
	endtask

	task automatic predict_gradient(pix_t it);
		int unsigned w, h, total, p, q;
		int sum;
		res_t next_res;
		w = clamp_dim(regs.line_width, MAX_WIDTH);
		h = clamp_dim(regs.line_count, MAX_HEIGHT);
		total = w * h;
		if (it.frame_start) rx_count = 0;
		p = rx_count;
		wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
		pix_hist[wr_ptr] = (it.is_pad || p >= total) ? '0 : it.pixel;
		if (rx_count < RX_LIMIT) rx_count++;
		if (p < w + 1) return;
		q = p - w - 1;
		if (q >= total) return;
		sum = regs.coef.up_left * nbr(p, 2 * w + 2)
			+ regs.coef.up_right * nbr(p, 2 * w)
			+ regs.coef.left * nbr(p, w + 2)
			+ regs.coef.right * nbr(p, w)
			+ regs.coef.down_left * nbr(p, 2)
			+ regs.coef.down_right * nbr(p, 0);
		next_res.gradient = sum[GRAD_W-1:0];
		next_res.frame_end = (q == total - 1);
		grad_queue.push_back(next_res);
	endtask

	task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (reg_idx_t'(idx))
			REG_COEF_UP_LEFT: regs.coef.up_left = data[COEF_W-1:0];
			REG_COEF_UP_RIGHT: regs.coef.up_right = data[COEF_W-1:0];
			REG_COEF_LEFT: regs.coef.left = data[COEF_W-1:0];
			REG_COEF_RIGHT: regs.coef.right = data[COEF_W-1:0];
			REG_COEF_DOWN_LEFT: regs.coef.down_left = data[COEF_W-1:0];
			REG_COEF_DOWN_RIGHT: regs.coef.down_right = data[COEF_W-1:0];
			REG_LINE_WIDTH: regs.line_width = data;
			REG_LINE_COUNT: regs.line_count = data;
			default: ;
		endcase
	endtask

	task automatic check_gradient(res_t got);
		res_t want;
		if (grad_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("checker: unexpected result gradient %0d frame_end %0b",
					got.gradient, got.frame_end);
			return;
		end
		want = grad_queue.pop_front();
		results_checked++;
		if (got.gradient !== want.gradient || got.frame_end !== want.frame_end) begin
			fail_count++;
			if (fail_count <= 10)
				$display("checker: result %0d expected gradient %0d frame_end %0b, got %0d %0b",
					results_checked, want.gradient, want.frame_end,
					got.gradient, got.frame_end);
		end
	endtask

	initial reset_model();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (pop && !empty) check_gradient(result);
			if (push && !full) predict_gradient(item);
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			pending = grad_queue.size();
		end
	end

endmodule

[tb/testbench.sv]
// testbench: drives pixel requests and register writes into
// sobel_x_gradient_stream and gives the verdict; checking is in sxg_checker.
// Depends on sxg_pkg, sxg_checker and the block's RTL.
module testbench import sxg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	pix_t                  item;
	logic                  empty;
	logic                  pop;
	res_t                  result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int          fail_count;
	int          pending;
	int          results_checked;
	int          send_idle_pct;
	int          pop_stall_pct;
	int          items_sent;
	int unsigned eff_w;
	int unsigned eff_h;
	bit          bright;

	sobel_x_gradient_stream DUT (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	sxg_checker grad_check (
		.clk, .arst_n, .push, .full, .item, .empty, .pop, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending, .results_checked
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

	always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

	function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		if (bright) return ($urandom_range(9) == 0) ? 8'($urandom) : 8'hFF;
		case ($urandom_range(7))
			0, 1: return 8'hFF;
			2: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(7))
			0: return -8'sd128;
			1: return 8'sd127;
			2: return 8'sd0;
			default: return coef_t'($urandom);
		endcase
	endfunction

	task automatic send_item(logic [PIX_W-1:0] px, logic pad, logic fs, bit counts);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= '{pixel: px, is_pad: pad, frame_start: fs};
		do @(posedge clk); while (full);
		if (counts) items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// upper data bits of a coefficient write are don't-care, so randomize them
	task automatic set_config(coefs_t c, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		write_reg(REG_COEF_UP_LEFT, {3'($urandom), c.up_left});
		write_reg(REG_COEF_UP_RIGHT, {3'($urandom), c.up_right});
		write_reg(REG_COEF_LEFT, {3'($urandom), c.left});
		write_reg(REG_COEF_RIGHT, {3'($urandom), c.right});
		write_reg(REG_COEF_DOWN_LEFT, {3'($urandom), c.down_left});
		write_reg(REG_COEF_DOWN_RIGHT, {3'($urandom), c.down_right});
		write_reg(REG_LINE_WIDTH, w);
		write_reg(REG_LINE_COUNT, h);
		cfg_valid <= 1'b0;
		eff_w = eff_dim(w);
		eff_h = eff_dim(h);
	endtask

	// one image, cut short (abandoned by the next frame start) when too big or by random choice
	task automatic send_image(bit fresh, int unsigned cap, bit counts);
		int unsigned total, n;
		bit cut;
		total = eff_w * eff_h;
		cut = (total > cap) || ($urandom_range(9) == 0);
		n = cut ? $urandom_range(total > cap ? cap : total, 1) : total;
		for (int unsigned i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(5) == 0) drain_results();
			send_item(rand_pixel(), $urandom_range(15) == 0, fresh && i == 0, counts);
		end
		if (!cut) begin
			for (int unsigned i = 0; i <= eff_w; i++)
				send_item(8'($urandom), 1'($urandom), 1'b0, counts);
			repeat ($urandom_range(3)) send_item(8'($urandom), 1'($urandom), 1'b0, 1'b0);
		end
	endtask

	initial begin
		coefs_t                c;
		logic [DIM_W-1:0]      w, h;
		int                    phase;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		items_sent = 0;
		bright = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset coefficients, 3x2 image with no frame start after reset
		write_reg(REG_LINE_WIDTH, 11'd3);
		write_reg(REG_LINE_COUNT, 11'd2);
		cfg_valid <= 1'b0;
		eff_w = eff_dim(11'd3);
		eff_h = eff_dim(11'd2);
		send_item(8'h00, 1'b0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0, 1'b1);
		send_item(8'h55, 1'b0, 1'b0, 1'b1);
		send_item(8'hAA, 1'b0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0, 1'b1);
		drain_results();
		send_item(8'hFF, 1'b0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0, 1'b1);
		send_item(8'h0F, 1'b1, 1'b0, 1'b1);
		send_item(8'hF0, 1'b0, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0, 1'b0);
		drain_results();

		// zero dimensions clamp to 1x1; second frame start abandons the first
		c = '{up_left: -8'sd128, up_right: 8'sd127, left: -8'sd128, right: 8'sd127,
			down_left: -8'sd128, down_right: 8'sd127};
		set_config(c, 11'd0, 11'd0);
		send_item(8'hFF, 1'b0, 1'b1, 1'b1);
		send_item(8'hC8, 1'b0, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b0, 1'b1);
		drain_results();

		phase = 0;
		while (items_sent < 1850) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; pop_stall_pct = 0; end
				1: begin send_idle_pct = 66; pop_stall_pct = 0; end
				2: begin send_idle_pct = 0; pop_stall_pct = 66; end
				default: begin send_idle_pct = 6; pop_stall_pct = 6; end
			endcase
			bright = (phase < 2);
			if (phase == 0) c = '{default: -8'sd128};
			else if (phase == 1) c = '{default: 8'sd127};
			else c = '{up_left: rand_coef(), up_right: rand_coef(), left: rand_coef(),
				right: rand_coef(), down_left: rand_coef(), down_right: rand_coef()};
			case ($urandom_range(5))
				0: w = 11'd0;
				1: w = 11'd1;
				default: w = 11'($urandom_range(12, 2));
			endcase
			case ($urandom_range(5))
				0: h = 11'd0;
				1: h = 11'd2047;
				default: h = 11'($urandom_range(5, 1));
			endcase
			if (phase == 2) begin
				// widest line, clamped; only a leading part of the image, then abandoned
				set_config(c, 11'd2047, 11'd3);
				send_image(1'b1, 1040, 1'b1);
			end else begin
				set_config(c, w, h);
				send_image($urandom_range(7) != 0, 60, 1'b1);
				repeat ($urandom_range(3)) send_image(1'b1, 60, 1'b1);
			end
			drain_results();
			phase++;
		end

		drain_results();
		$display("tb: %0d pixel requests over %0d register settings, %0d gradients checked",
			items_sent, phase + 2, results_checked);
		$display("tb: idle patterns none, sender only, receiver only and both lightly");
		if (fail_count == 0 && pending == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
